/* rtl/core/cbq_pkg.sv */
package cbq_pkg;

  localparam int ACC_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int SCALE_W  = 18;
  localparam int NSEC_W   = 4;
  localparam int CSEC_W   = 3;
  localparam int CIDX_W   = 3;
  localparam int OUT_W    = 18;
  localparam int NCOEF    = 5;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic signed [SCALE_W-1:0] SCALE_RST = 18'sd16384;
  localparam logic [NSEC_W-1:0]         NSEC_RST  = 4'd1;

  // Configuration register indexes.
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_NSEC  = 1'b1;

  // Coefficient slots within one section.
  localparam logic [CIDX_W-1:0] COEF_A1 = 3'd0;
  localparam logic [CIDX_W-1:0] COEF_A2 = 3'd1;
  localparam logic [CIDX_W-1:0] COEF_B0 = 3'd2;
  localparam logic [CIDX_W-1:0] COEF_B1 = 3'd3;
  localparam logic [CIDX_W-1:0] COEF_B2 = 3'd4;

  // Steps of one section pass.
  localparam logic [2:0] STEP_RD_A1  = 3'd0;
  localparam logic [2:0] STEP_RD_A2  = 3'd1;
  localparam logic [2:0] STEP_RD_B1  = 3'd2;
  localparam logic [2:0] STEP_RD_B2  = 3'd3;
  localparam logic [2:0] STEP_RD_B0  = 3'd4;
  localparam logic [2:0] STEP_ACC_B2 = 3'd5;
  localparam logic [2:0] STEP_ACC_B0 = 3'd6;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCALE,
    ENG_LOAD,
    ENG_SEC,
    ENG_DONE
  } eng_state_e;

  typedef struct packed {
    logic coef_re;
    logic hist_re;
    logic hist_we;
  } mem_ctrl_t;

endpackage

/* rtl/core/cbq_if.sv */
interface cbq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic signed [cbq_pkg::SAMPLE_W-1:0]      sample;
  logic        [cbq_pkg::CSEC_W-1:0]        coef_section;
  logic        [cbq_pkg::CIDX_W-1:0]        coef_index;
  logic signed [cbq_pkg::COEF_W-1:0]        coef_value;

  modport source (output valid, mode, sample, coef_section, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, mode, sample, coef_section, coef_index, coef_value,
                  output ready);
endinterface

interface cbq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbq_pkg::OUT_W-1:0]     filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

/* rtl/core/cascaded_biquad_iir_filter_unit.sv */
// Cascaded biquad IIR filter, Q14 fixed point, direct form II.
// Input channel in_i carries one item at a time. A coefficient item (mode 1)
// writes one of a1, a2, b0, b1, b2 of one section in the cycle it is taken
// and gives no result. A sample item (mode 0) is scaled by input_scale and
// run through active_sections sections; it gives one item on out_o.
// All section arithmetic goes through one shared 18-bit multiplier, one
// product per cycle, with coefficients and history words read from two
// synchronous memories.
// The next item is taken in the cycle its predecessor's result appears; a
// coefficient item leaves the block idle. Each section pass runs the five
// taps through the multiplier plus the read and accumulate steps around it.
// Results sit in an output register; if the receiver stalls, one finished
// result waits there and the block still takes a new item, holding its next
// result until the register is free.
// Reset clears all coefficients and history to zero at once (valid bits, no
// clearing pass), sets input_scale to 1.0 and active_sections to one.
// Configuration is to be written by the user over the APB port only while no
// sample is in work; the block itself does not enforce this.
module cascaded_biquad_iir_filter_unit #(
  parameter int MAX_SECTIONS = 8,
  parameter int FRAC_BITS    = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cbq_in_if.sink                          in_i,
  cbq_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbq_pkg::APB_AW-1:0]      paddr,
  input  logic [cbq_pkg::APB_DW-1:0]      pwdata,
  output logic [cbq_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int HW    = cbq_pkg::ACC_W - FRAC_BITS;
  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic signed [cbq_pkg::SCALE_W-1:0] scale_q;
  logic [cbq_pkg::NSEC_W-1:0]         nsec_q;
  logic                               reg_idx;
  logic                               cfg_wr;

  logic                               in_acc;
  logic                               eng_idle;
  logic                               cw_en;
  cbq_pkg::mem_ctrl_t                 mem_ctrl;
  logic [SEC_W-1:0]                   eng_sec;
  logic [cbq_pkg::CIDX_W-1:0]         eng_k;
  logic [2*HW-1:0]                    hist_wdata;
  logic signed [cbq_pkg::COEF_W-1:0]  coef_rd;
  logic [2*HW-1:0]                    hist_rd;
  logic                               res_valid;
  logic signed [cbq_pkg::OUT_W-1:0]   res;
  logic                               out_free;

  logic                               out_valid_q;
  logic signed [cbq_pkg::OUT_W-1:0]   filtered_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= cbq_pkg::SCALE_RST;
      nsec_q  <= cbq_pkg::NSEC_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        cbq_pkg::REG_SCALE: scale_q <= pwdata[cbq_pkg::SCALE_W-1:0];
        cbq_pkg::REG_NSEC:  nsec_q  <= pwdata[cbq_pkg::NSEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cbq_pkg::REG_SCALE: prdata = cbq_pkg::APB_DW'(scale_q);
      cbq_pkg::REG_NSEC:  prdata = cbq_pkg::APB_DW'(nsec_q);
      default:            prdata = '0;
    endcase
  end

  // Input side.
  assign in_i.ready = eng_idle;
  assign in_acc     = in_i.valid && eng_idle;
  assign cw_en      = in_acc && in_i.mode
                      && (32'(in_i.coef_index) < cbq_pkg::NCOEF)
                      && (32'(in_i.coef_section) < MAX_SECTIONS);

  cbq_engine #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_acc && !in_i.mode),
    .sample_i     (in_i.sample),
    .scale_i      (scale_q),
    .active_i     (nsec_q),
    .out_free_i   (out_free),
    .coef_i       (coef_rd),
    .hist_i       (hist_rd),
    .ctrl_o       (mem_ctrl),
    .sec_o        (eng_sec),
    .coef_k_o     (eng_k),
    .hist_wdata_o (hist_wdata),
    .idle_o       (eng_idle),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  cbq_mem #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .HW           (HW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mem_ctrl),
    .rd_sec_i     (eng_sec),
    .rd_k_i       (eng_k),
    .hist_wdata_i (hist_wdata),
    .cw_en_i      (cw_en),
    .cw_sec_i     (SEC_W'(in_i.coef_section)),
    .cw_k_i       (in_i.coef_index),
    .cw_data_i    (in_i.coef_value),
    .coef_o       (coef_rd),
    .hist_o       (hist_rd)
  );

  // Output register.
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      filtered_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = filtered_q;

endmodule

/* rtl/core/cbq_mem.sv */
module cbq_mem #(
  parameter int MAX_SECTIONS = 8,
  parameter int HW           = 18,
  localparam int SEC_W       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cbq_pkg::mem_ctrl_t                    ctrl_i,
  input  logic [SEC_W-1:0]                      rd_sec_i,
  input  logic [cbq_pkg::CIDX_W-1:0]            rd_k_i,
  input  logic [2*HW-1:0]                       hist_wdata_i,
  input  logic                                  cw_en_i,
  input  logic [SEC_W-1:0]                      cw_sec_i,
  input  logic [cbq_pkg::CIDX_W-1:0]            cw_k_i,
  input  logic signed [cbq_pkg::COEF_W-1:0]     cw_data_i,
  output logic signed [cbq_pkg::COEF_W-1:0]     coef_o,
  output logic [2*HW-1:0]                       hist_o
);

  localparam int CDEPTH = MAX_SECTIONS * cbq_pkg::NCOEF;
  localparam int CA_W   = $clog2(CDEPTH);

  logic [cbq_pkg::COEF_W-1:0] coef_mem [CDEPTH];
  logic [2*HW-1:0]            hist_mem [MAX_SECTIONS];

  // Never-written entries read as zero through these valid bits.
  logic [CDEPTH-1:0]       coef_vld_q;
  logic [MAX_SECTIONS-1:0] hist_vld_q;

  logic [cbq_pkg::COEF_W-1:0] coef_rd_q;
  logic                       coef_rdv_q;
  logic [2*HW-1:0]            hist_rd_q;
  logic                       hist_rdv_q;

  logic [CA_W-1:0] cw_addr;
  logic [CA_W-1:0] cr_addr;

  assign cw_addr = CA_W'(32'(cw_sec_i) * cbq_pkg::NCOEF + 32'(cw_k_i));
  assign cr_addr = CA_W'(32'(rd_sec_i) * cbq_pkg::NCOEF + 32'(rd_k_i));

  always_ff @(posedge clk_i) begin
    if (cw_en_i) begin
      coef_mem[cw_addr] <= cw_data_i;
    end
    if (ctrl_i.coef_re) begin
      coef_rd_q <= coef_mem[cr_addr];
    end
  end

  // The history row is written back while the same row's read data is held,
  // and the next read of that row comes only with the next item.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.hist_we) begin
      hist_mem[rd_sec_i] <= hist_wdata_i;
    end
    if (ctrl_i.hist_re) begin
      hist_rd_q <= hist_mem[rd_sec_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      coef_rdv_q <= 1'b0;
      hist_rdv_q <= 1'b0;
    end else begin
      if (cw_en_i) begin
        coef_vld_q[cw_addr] <= 1'b1;
      end
      if (ctrl_i.hist_we) begin
        hist_vld_q[rd_sec_i] <= 1'b1;
      end
      if (ctrl_i.coef_re) begin
        coef_rdv_q <= coef_vld_q[cr_addr];
      end
      if (ctrl_i.hist_re) begin
        hist_rdv_q <= hist_vld_q[rd_sec_i];
      end
    end
  end

  assign coef_o = coef_rdv_q ? $signed(coef_rd_q) : '0;
  assign hist_o = hist_rdv_q ? hist_rd_q : '0;

endmodule

/* rtl/core/cbq_engine.sv */
module cbq_engine #(
  parameter int MAX_SECTIONS = 8,
  parameter int FRAC_BITS    = 14,
  localparam int HW          = cbq_pkg::ACC_W - FRAC_BITS,
  localparam int SEC_W       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic signed [cbq_pkg::SCALE_W-1:0]    scale_i,
  input  logic [cbq_pkg::NSEC_W-1:0]            active_i,
  input  logic                                  out_free_i,
  input  logic signed [cbq_pkg::COEF_W-1:0]     coef_i,
  input  logic [2*HW-1:0]                       hist_i,
  output cbq_pkg::mem_ctrl_t                    ctrl_o,
  output logic [SEC_W-1:0]                      sec_o,
  output logic [cbq_pkg::CIDX_W-1:0]            coef_k_o,
  output logic [2*HW-1:0]                       hist_wdata_o,
  output logic                                  idle_o,
  output logic                                  res_valid_o,
  output logic signed [cbq_pkg::OUT_W-1:0]      res_o
);

  localparam int OPB_W  = (HW > cbq_pkg::SAMPLE_W) ? HW : cbq_pkg::SAMPLE_W;
  localparam int PROD_W = cbq_pkg::COEF_W + OPB_W;
  localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);

  cbq_pkg::eng_state_e state_q, state_d;
  logic [2:0]       step_q, step_d;
  logic [SEC_W-1:0] sec_q, sec_d;

  logic [cbq_pkg::ACC_W-1:0] x_q, x_d;
  logic [cbq_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [cbq_pkg::ACC_W-1:0] prod_q;

  logic [CNT_W-1:0]          nsec;
  logic                      last_sec;
  logic [HW-1:0]             w1, w2, w_new;
  logic signed [cbq_pkg::COEF_W-1:0] opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [cbq_pkg::ACC_W-1:0] x_shr;

  always_comb begin
    if (32'(active_i) > MAX_SECTIONS) begin
      nsec = CNT_W'(MAX_SECTIONS);
    end else begin
      nsec = CNT_W'(active_i);
    end
  end

  assign last_sec = (32'(sec_q) + 32'd1) == 32'(nsec);

  assign w1    = hist_i[HW-1:0];
  assign w2    = hist_i[2*HW-1:HW];
  assign w_new = acc_q[cbq_pkg::ACC_W-1:FRAC_BITS];

  // Shared multiplier: the scale product first, then five taps per section.
  // The scale product is formed while the sample is still on the input.
  always_comb begin
    if (state_q == cbq_pkg::ENG_IDLE) begin
      opa = scale_i;
      opb = OPB_W'(sample_i);
    end else begin
      opa = coef_i;
      if (step_q inside {cbq_pkg::STEP_RD_A2, cbq_pkg::STEP_RD_B2}) begin
        opb = OPB_W'($signed(w1));
      end else if (step_q inside {cbq_pkg::STEP_RD_B1, cbq_pkg::STEP_RD_B0}) begin
        opb = OPB_W'($signed(w2));
      end else begin
        opb = OPB_W'($signed(w_new));
      end
    end
  end

  assign prod_full = opa * opb;

  assign x_shr = $signed(x_q) >>> FRAC_BITS;
  assign res_o = x_shr[cbq_pkg::OUT_W-1:0];

  assign sec_o        = sec_q;
  assign hist_wdata_o = {w1, w_new};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sec_d       = sec_q;
    x_d         = x_q;
    acc_d       = acc_q;
    ctrl_o      = '0;
    coef_k_o    = cbq_pkg::COEF_A1;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      cbq_pkg::ENG_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          state_d = cbq_pkg::ENG_SCALE;
        end
      end
      cbq_pkg::ENG_SCALE: begin
        x_d     = prod_q;
        state_d = cbq_pkg::ENG_LOAD;
      end
      cbq_pkg::ENG_LOAD: begin
        step_d = cbq_pkg::STEP_RD_A1;
        sec_d  = '0;
        if (nsec == '0) begin
          state_d = cbq_pkg::ENG_DONE;
        end else begin
          state_d = cbq_pkg::ENG_SEC;
        end
      end
      cbq_pkg::ENG_SEC: begin
        // Feedback taps go first so that w is ready before b0 is read.
        step_d = step_q + 3'd1;
        case (step_q)
          cbq_pkg::STEP_RD_A1: begin
            ctrl_o.coef_re = 1'b1;
            ctrl_o.hist_re = 1'b1;
            coef_k_o       = cbq_pkg::COEF_A1;
            acc_d          = x_q;
          end
          cbq_pkg::STEP_RD_A2: begin
            ctrl_o.coef_re = 1'b1;
            coef_k_o       = cbq_pkg::COEF_A2;
          end
          cbq_pkg::STEP_RD_B1: begin
            ctrl_o.coef_re = 1'b1;
            coef_k_o       = cbq_pkg::COEF_B1;
            acc_d          = acc_q - prod_q;
          end
          cbq_pkg::STEP_RD_B2: begin
            ctrl_o.coef_re = 1'b1;
            coef_k_o       = cbq_pkg::COEF_B2;
            acc_d          = acc_q - prod_q;
          end
          cbq_pkg::STEP_RD_B0: begin
            ctrl_o.coef_re = 1'b1;
            ctrl_o.hist_we = 1'b1;
            coef_k_o       = cbq_pkg::COEF_B0;
            x_d            = prod_q;
          end
          cbq_pkg::STEP_ACC_B2: begin
            x_d = x_q + prod_q;
          end
          cbq_pkg::STEP_ACC_B0: begin
            x_d    = x_q + prod_q;
            step_d = cbq_pkg::STEP_RD_A1;
            if (last_sec) begin
              state_d = cbq_pkg::ENG_DONE;
            end else begin
              sec_d = sec_q + SEC_W'(1);
            end
          end
          default: begin
            step_d = cbq_pkg::STEP_RD_A1;
          end
        endcase
      end
      cbq_pkg::ENG_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = cbq_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_d = cbq_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbq_pkg::ENG_IDLE;
      step_q  <= cbq_pkg::STEP_RD_A1;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_full[cbq_pkg::ACC_W-1:0];
  end

endmodule

/* rtl/core/cbq_checker.sv */
module cbq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A waiting result stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A coefficient item never makes a result.
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i && !out_valid_i |=> !out_valid_i)
    else $error("coefficient item produced a result");

  // A sample keeps the input closed while it is filtered.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_mode_i |=> !in_ready_i)
    else $error("input taken while a sample is in work");

  // A new result only comes out of a busy period.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a sample in work");

endmodule

bind cascaded_biquad_iir_filter_unit cbq_checker u_cbq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
